// ===== sv/nsv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character constants and lookup functions for the sentence validator.
// No dependencies; the stage, parser and top modules import this package.
package nsv_pkg;

  typedef enum logic [1:0] {
    PH_DOLLAR  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SUM     = 2'd2,
    PH_ERROR   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_REJECT = 2'd0,
    KIND_IMU    = 2'd1,
    KIND_RRG    = 2'd2
  } kind_e;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [3:0] TOK_MAX     = 4'd15;
  localparam logic [3:0] TOK_MIN_IMU = 4'd12;
  localparam logic [3:0] TOK_MIN_RRG = 4'd6;
  localparam logic [2:0] HDR_LEN     = 3'd5;
  localparam logic [2:0] REG_ID_LEN  = 3'd2;
  localparam logic [2:0] POS_MAX     = 3'd7;

  localparam logic [1:0] HEX_NONE = 2'd0;
  localparam logic [1:0] HEX_ONE  = 2'd1;
  localparam logic [1:0] HEX_TWO  = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [3:0] field_number;
    logic       is_field_data;
    logic       line_done;
    logic       checksum_ok;
    kind_e      sentence_kind;
  } res_item_t;

  // "VNIMU"
  function automatic logic [7:0] imu_hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h56;
      3'd1:    ch = 8'h4E;
      3'd2:    ch = 8'h49;
      3'd3:    ch = 8'h4D;
      3'd4:    ch = 8'h55;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "VNRRG"
  function automatic logic [7:0] rrg_hdr_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h56;
      3'd1:    ch = 8'h4E;
      3'd2:    ch = 8'h52;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h47;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "09"
  function automatic logic [7:0] reg_id_char(input logic pos);
    return pos ? 8'h39 : 8'h30;
  endfunction

  // Bit 4 set: not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

// ===== sv/nsv_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sentence bytes in and annotated bytes out.
// Depends on nothing; payload fields carry the plain item layout.
interface nsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;

  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

interface nsv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [3:0] field_number;
  logic       is_field_data;
  logic       line_done;
  logic       checksum_ok;
  logic [1:0] sentence_kind;

  modport source (output valid, output char_out, output field_number, output is_field_data,
                  output line_done, output checksum_ok, output sentence_kind, input ready);
  modport sink   (input valid, input char_out, input field_number, input is_field_data,
                  input line_done, input checksum_ok, input sentence_kind, output ready);
endinterface

// ===== sv/nsv_in_stage.sv =====
`timescale 1ns / 1ps
// Input register stage: captures one byte transaction per cycle unless the downstream stage stalls.
// Depends on nsv_pkg for the item type.
module nsv_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  nsv_pkg::in_item_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output nsv_pkg::in_item_t item_o
);
  import nsv_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ===== sv/nsv_parser.sv =====
`timescale 1ns / 1ps
// Per-sentence parse state and the single-pass update for one byte:
// framing, running XOR, hex checksum capture, token counting, header and register-ID match.
// Depends on nsv_pkg.
module nsv_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  nsv_pkg::in_item_t  item_i,
  output nsv_pkg::res_item_t res_o
);
  import nsv_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] exp_q, exp_d;
  logic [1:0] hex_seen_q, hex_seen_d;
  logic [3:0] tok_q, tok_d;
  logic [2:0] pos_q, pos_d;
  logic       imu_q, imu_d;
  logic       rrg_q, rrg_d;
  logic       regid_q, regid_d;
  logic       prev_comma_q, prev_comma_d;
  logic       nonempty_q, nonempty_d;

  logic [7:0] c;
  logic [4:0] hv;
  logic [3:0] tokens;
  logic       data;
  logic       ok;
  kind_e      kind;

  always_comb begin
    c            = item_i.char_in;
    hv           = hex_value(c);
    phase_d      = phase_q;
    xor_d        = xor_q;
    exp_d        = exp_q;
    hex_seen_d   = hex_seen_q;
    tok_d        = tok_q;
    pos_d        = pos_q;
    imu_d        = imu_q;
    rrg_d        = rrg_q;
    regid_d      = regid_q;
    prev_comma_d = prev_comma_q;
    nonempty_d   = nonempty_q;
    data         = 1'b0;
    tokens       = '0;
    ok           = 1'b0;
    kind         = KIND_REJECT;

    unique case (phase_q)
      PH_DOLLAR: begin
        phase_d = (c == CH_DOLLAR) ? PH_PAYLOAD : PH_ERROR;
      end
      PH_PAYLOAD: begin
        if (c != CH_STAR) begin
          xor_d      = xor_q ^ c;
          nonempty_d = 1'b1;
        end
        if (c == CH_STAR || c == CH_COMMA) begin
          // close the current token
          if (tok_q == 4'd0 && pos_q != HDR_LEN) begin
            imu_d = 1'b0;
            rrg_d = 1'b0;
          end
          if (tok_q == 4'd1 && pos_q != REG_ID_LEN) begin
            regid_d = 1'b0;
          end
          pos_d = '0;
        end
        if (c == CH_STAR) begin
          phase_d = PH_SUM;
        end else if (c == CH_COMMA) begin
          if (tok_q < TOK_MAX) begin
            tok_d = tok_q + 4'd1;
          end
          prev_comma_d = 1'b1;
        end else begin
          data         = 1'b1;
          prev_comma_d = 1'b0;
          if (tok_q == 4'd0) begin
            if (pos_q >= HDR_LEN) begin
              imu_d = 1'b0;
              rrg_d = 1'b0;
            end else begin
              if (c != imu_hdr_char(pos_q)) imu_d = 1'b0;
              if (c != rrg_hdr_char(pos_q)) rrg_d = 1'b0;
            end
          end else if (tok_q == 4'd1) begin
            if (pos_q >= REG_ID_LEN || c != reg_id_char(pos_q[0])) regid_d = 1'b0;
          end
          if (pos_q < POS_MAX) begin
            pos_d = pos_q + 3'd1;
          end
        end
      end
      PH_SUM: begin
        if (hex_seen_q == HEX_NONE) begin
          if (hv[4]) phase_d = PH_ERROR;
          else       exp_d   = {4'h0, hv[3:0]};
          hex_seen_d = HEX_ONE;
        end else if (hex_seen_q == HEX_ONE) begin
          // a non-hex second digit keeps the one-digit value
          if (!hv[4]) exp_d = {exp_q[3:0], hv[3:0]};
          hex_seen_d = HEX_TWO;
        end
      end
      PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (item_i.end_of_line) begin
      tokens = tok_d;
      if (nonempty_d && !prev_comma_d && tok_d < TOK_MAX) begin
        tokens = tok_d + 4'd1;
      end
      ok = (phase_d == PH_SUM) && (hex_seen_d == HEX_TWO) && (xor_d == exp_d);
      if (ok) begin
        if (imu_d && tokens >= TOK_MIN_IMU) begin
          kind = KIND_IMU;
        end else if (rrg_d && regid_d && tokens >= TOK_MIN_RRG) begin
          kind = KIND_RRG;
        end
      end
    end

    res_o.char_out      = c;
    res_o.field_number  = tok_q;
    res_o.is_field_data = data;
    res_o.line_done     = item_i.end_of_line;
    res_o.checksum_ok   = ok;
    res_o.sentence_kind = kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_DOLLAR;
      xor_q        <= '0;
      exp_q        <= '0;
      hex_seen_q   <= HEX_NONE;
      tok_q        <= '0;
      pos_q        <= '0;
      imu_q        <= 1'b1;
      rrg_q        <= 1'b1;
      regid_q      <= 1'b1;
      prev_comma_q <= 1'b0;
      nonempty_q   <= 1'b0;
    end else if (fire_i) begin
      if (item_i.end_of_line) begin
        // sentence finished: return to the idle state
        phase_q      <= PH_DOLLAR;
        xor_q        <= '0;
        exp_q        <= '0;
        hex_seen_q   <= HEX_NONE;
        tok_q        <= '0;
        pos_q        <= '0;
        imu_q        <= 1'b1;
        rrg_q        <= 1'b1;
        regid_q      <= 1'b1;
        prev_comma_q <= 1'b0;
        nonempty_q   <= 1'b0;
      end else begin
        phase_q      <= phase_d;
        xor_q        <= xor_d;
        exp_q        <= exp_d;
        hex_seen_q   <= hex_seen_d;
        tok_q        <= tok_d;
        pos_q        <= pos_d;
        imu_q        <= imu_d;
        rrg_q        <= rrg_d;
        regid_q      <= regid_d;
        prev_comma_q <= prev_comma_d;
        nonempty_q   <= nonempty_d;
      end
    end
  end

endmodule

// ===== sv/nsv_out_stage.sv =====
`timescale 1ns / 1ps
// Result register stage: holds one finished result until the sink takes it.
// Depends on nsv_pkg for the result type.
module nsv_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  nsv_pkg::res_item_t res_i,
  output logic               valid_o,
  input  logic               ready_i,
  output nsv_pkg::res_item_t res_o
);
  import nsv_pkg::*;

  logic      valid_q;
  res_item_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== sv/nmea_sentence_validator_top.sv =====
`timescale 1ns / 1ps
// Sentence validator top level: input register, byte parser, result register.
// A byte accepted into the input register is parsed combinationally, and its result is
// registered in the result register; the parse state updates once per byte in one pass.
// Throughput: one byte per cycle unless the sink stalls both stages.
// Reset (async, active low) empties both stages and returns the parser to expecting '$'.
// Depends on nsv_pkg, nsv_stream_if, nsv_in_stage, nsv_parser and nsv_out_stage.
module nmea_sentence_validator_top (
  input  logic clk_i,
  input  logic rst_ni,
  nsv_in_if.sink    in_i,
  nsv_out_if.source out_o
);
  import nsv_pkg::*;

  in_item_t  in_item;
  in_item_t  stage_item;
  res_item_t parse_res;
  res_item_t out_res;
  logic      stage_valid;
  logic      res_ready;
  logic      in_ready;
  logic      out_valid;

  assign in_item.char_in     = in_i.char_in;
  assign in_item.end_of_line = in_i.end_of_line;
  assign in_i.ready          = in_ready;

  nsv_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_ready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .ready_i (res_ready),
    .item_o  (stage_item)
  );

  nsv_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (stage_valid && res_ready),
    .item_i (stage_item),
    .res_o  (parse_res)
  );

  nsv_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .ready_o (res_ready),
    .res_i   (parse_res),
    .valid_o (out_valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.valid         = out_valid;
  assign out_o.char_out      = out_res.char_out;
  assign out_o.field_number  = out_res.field_number;
  assign out_o.is_field_data = out_res.is_field_data;
  assign out_o.line_done     = out_res.line_done;
  assign out_o.checksum_ok   = out_res.checksum_ok;
  assign out_o.sentence_kind = out_res.sentence_kind;

endmodule
